/* rtl/fll_pkg.sv */
// Shared types, codes and helper functions for the fixed-field line editor.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package fll_pkg;

    typedef logic [7:0] t_byte;

    // Item opcodes.
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_LOAD  = 2'd0;
    localparam t_opcode OP_BEGIN = 2'd1;
    localparam t_opcode OP_KEY   = 2'd2;

    // Result kinds.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_STATUS = 2'd0;
    localparam t_kind KIND_CHAR   = 2'd1;
    localparam t_kind KIND_REFUSE = 2'd2;

    // Key codes.
    localparam t_byte KEY_BKSP  = 8'h08;
    localparam t_byte KEY_LEFT  = 8'h0E;
    localparam t_byte KEY_RIGHT = 8'h12;
    localparam t_byte KEY_INS   = 8'hF1;
    localparam t_byte KEY_DEL   = 8'hF2;
    localparam t_byte KEY_HOME  = 8'hF3;
    localparam t_byte KEY_END   = 8'hF4;
    localparam t_byte KEY_CLR_A = 8'hFE;
    localparam t_byte KEY_CLR_B = 8'hFF;

    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_NONE  = 8'h00;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_EXIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_JUSTIFY = 2'd2;
    localparam logic [CFG_DATA_W-1:0] FIELD_WIDTH_RESET = 7'd64;

    // Commands broadcast to the row of cells.
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD = 2'd0;
    localparam t_cell_op CELL_FILL = 2'd1;
    localparam t_cell_op CELL_SHL  = 2'd2;
    localparam t_cell_op CELL_SHR  = 2'd3;

    typedef struct packed {
        t_cell_op op;
        t_byte    value;
    } t_cell_cmd;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_opcode    opcode;
        logic [5:0] char_index;
        t_byte      char_value;
        logic [6:0] start_cursor;
        t_byte      key_code;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] cursor;
        logic       insert_on;
        logic       was_modified;
        logic       is_empty;
        logic       auto_exited;
        t_byte      exit_key;
        logic [5:0] out_index;
        t_byte      out_char;
        logic       last;
    } t_result;

    function automatic logic is_printable(input t_byte c);
        is_printable = c inside {[8'h20:8'h7E]};
    endfunction

    function automatic logic is_blank(input t_byte c);
        is_blank = c inside {CH_SPACE, CH_TAB};
    endfunction

endpackage

/* rtl/fll_cell.sv */
// One character cell of the field: holds a byte and takes a neighbor's byte on shifts.
// Depends on fll_pkg for the cell command type.
`timescale 1ns / 1ps

module fll_cell
    import fll_pkg::*;
#(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  t_cell_cmd     i_cmd,
    input  logic [CW-1:0] i_lo,
    input  logic [CW-1:0] i_hi,
    input  t_byte         i_left,
    input  t_byte         i_right,
    output t_byte         o_q
);

    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    t_byte r_q;
    t_byte n_q;

    always_comb begin
        n_q = r_q;
        case (i_cmd.op)
            CELL_FILL: begin
                if (i_lo <= MY_POS && MY_POS <= i_hi) n_q = i_cmd.value;
            end
            CELL_SHL: begin
                // The top cell of the range empties; the rest take from above.
                if (MY_POS == i_hi) begin
                    n_q = CH_NONE;
                end else if (i_lo <= MY_POS && MY_POS < i_hi) begin
                    n_q = i_right;
                end
            end
            CELL_SHR: begin
                if (MY_POS == i_lo) begin
                    n_q = i_cmd.value;
                end else if (i_lo < MY_POS && MY_POS <= i_hi) begin
                    n_q = i_left;
                end
            end
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

/* rtl/fll_ctrl.sv */
// Sequencer of the line editor: decodes items, drives the cell row, scans the cells
// through one registered read port and holds the output register. Depends on fll_pkg.
`timescale 1ns / 1ps

module fll_ctrl
    import fll_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_cfg_wr                              i_cfg,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  t_item                                i_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output t_result                              o_res,
    input  t_byte                                i_cells [MAX_WIDTH],
    output t_cell_cmd                            o_cmd,
    output logic [$clog2(MAX_WIDTH + 1) - 1:0]   o_lo,
    output logic [$clog2(MAX_WIDTH + 1) - 1:0]   o_hi
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISP      = 4'd1;
    localparam logic [3:0] ST_KEY       = 4'd2;
    localparam logic [3:0] ST_AX_ADDR   = 4'd3;
    localparam logic [3:0] ST_AX_CHK    = 4'd4;
    localparam logic [3:0] ST_RIGHT     = 4'd5;
    localparam logic [3:0] ST_TL        = 4'd6;
    localparam logic [3:0] ST_TR_ADDR   = 4'd7;
    localparam logic [3:0] ST_TR_CHK    = 4'd8;
    localparam logic [3:0] ST_BEGIN_FIN = 4'd9;
    localparam logic [3:0] ST_LEN_ADDR  = 4'd10;
    localparam logic [3:0] ST_LEN       = 4'd11;
    localparam logic [3:0] ST_SHIFT     = 4'd12;
    localparam logic [3:0] ST_EMIT      = 4'd13;
    localparam logic [3:0] ST_ONE       = 4'd14;

    localparam logic [CW-1:0] POS_ONE = CW'(1);
    localparam logic [CW-1:0] POS_MAX = CW'(MAX_WIDTH);

    logic [3:0]            r_state, n_state;
    t_item                 r_item, n_item;
    logic [CW-1:0]         r_cursor, n_cursor;
    logic                  r_ins, n_ins;
    logic                  r_mod, n_mod;
    logic                  r_empty, n_empty;
    logic [CFG_DATA_W-1:0] r_fw;
    logic                  r_autoexit;
    logic                  r_rj;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_seen, n_seen;
    logic                  r_exit, n_exit;
    t_byte                 r_xkey, n_xkey;
    logic                  r_xauto, n_xauto;
    t_kind                 r_kind, n_kind;
    t_byte                 r_rd;
    logic                  r_ovalid;
    t_result               r_out;

    logic [CW-1:0] w_width;
    logic [CW-1:0] w_last;
    logic [CW-1:0] w_rd_addr;
    logic          w_out_free;
    logic          w_emit;
    t_result       w_res;
    t_byte         w_char;

    // Field width in use: zero acts as one, anything above the array as its size.
    always_comb begin
        if (r_fw == '0) begin
            w_width = POS_ONE;
        end else if (r_fw > MAX_WIDTH) begin
            w_width = POS_MAX;
        end else begin
            w_width = CW'(r_fw);
        end
    end

    assign w_last     = w_width - POS_ONE;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_char     = (r_seen || r_rd == CH_NONE) ? CH_SPACE : r_rd;

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_cursor  = r_cursor;
        n_ins     = r_ins;
        n_mod     = r_mod;
        n_empty   = r_empty;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_seen    = r_seen;
        n_exit    = r_exit;
        n_xkey    = r_xkey;
        n_xauto   = r_xauto;
        n_kind    = r_kind;
        o_cmd     = '{op: CELL_HOLD, value: CH_NONE};
        o_lo      = '0;
        o_hi      = w_last;
        w_rd_addr = '0;
        w_emit    = 1'b0;
        w_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_item;
                    n_cursor = (r_cursor > w_width) ? w_width : r_cursor;
                    n_state  = ST_DISP;
                end
            end

            ST_DISP: begin
                n_kind  = KIND_STATUS;
                n_state = ST_ONE;
                case (r_item.opcode)
                    OP_LOAD: begin
                        if (r_item.char_index < MAX_WIDTH) begin
                            o_cmd = '{op: CELL_FILL, value: r_item.char_value};
                            o_lo  = CW'(r_item.char_index);
                            o_hi  = CW'(r_item.char_index);
                        end
                        n_state = ST_IDLE;
                    end
                    OP_BEGIN: begin
                        n_mod    = 1'b0;
                        n_exit   = 1'b0;
                        n_cursor = (r_item.start_cursor > w_width) ? w_width
                                                                   : CW'(r_item.start_cursor);
                        n_state  = r_rj ? ST_TL : ST_TR_ADDR;
                    end
                    OP_KEY: begin
                        if (is_printable(r_item.key_code)) begin
                            n_mod     = 1'b1;
                            n_empty   = 1'b0;
                            w_rd_addr = w_last;
                            n_state   = ST_KEY;
                        end else begin
                            case (r_item.key_code)
                                KEY_BKSP: begin
                                    if (r_cursor != '0) begin
                                        if (r_ins) begin
                                            o_cmd = '{op: CELL_SHL, value: CH_NONE};
                                            o_lo  = r_cursor - POS_ONE;
                                        end
                                        n_cursor = r_cursor - POS_ONE;
                                    end
                                end
                                KEY_LEFT: begin
                                    if (r_cursor != '0) n_cursor = r_cursor - POS_ONE;
                                end
                                KEY_RIGHT: begin
                                    w_rd_addr = (r_cursor < w_width) ? r_cursor : '0;
                                    n_state   = ST_RIGHT;
                                end
                                KEY_INS: begin
                                    n_ins = !r_ins;
                                end
                                KEY_DEL: begin
                                    if (r_cursor < w_width) begin
                                        o_cmd = '{op: CELL_SHL, value: CH_NONE};
                                        o_lo  = r_cursor;
                                    end
                                end
                                KEY_HOME: begin
                                    n_cursor = '0;
                                end
                                KEY_END: begin
                                    n_ptr   = '0;
                                    n_exit  = 1'b0;
                                    n_state = ST_LEN;
                                end
                                KEY_CLR_A, KEY_CLR_B: begin
                                    o_cmd    = '{op: CELL_FILL, value: CH_NONE};
                                    n_cursor = '0;
                                    n_empty  = 1'b1;
                                end
                                default: begin
                                    n_xkey  = r_item.key_code;
                                    n_xauto = 1'b0;
                                    n_exit  = 1'b1;
                                    n_ptr   = '0;
                                    n_seen  = 1'b0;
                                    n_state = r_rj ? ST_TR_ADDR : ST_EMIT;
                                end
                            endcase
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_KEY: begin
                if (r_ins && is_printable(r_rd)) begin
                    n_kind  = KIND_REFUSE;
                    n_state = ST_ONE;
                end else begin
                    if (r_cursor < w_width) begin
                        // Insert opens a gap at the cursor; the shift stops at the last cell of the field.
                        o_cmd    = '{op: r_ins ? CELL_SHR : CELL_FILL, value: r_item.key_code};
                        o_lo     = r_cursor;
                        o_hi     = r_ins ? w_last : r_cursor;
                        n_cursor = r_cursor + POS_ONE;
                    end
                    n_state = r_autoexit ? ST_AX_ADDR : ST_ONE;
                end
            end

            ST_AX_ADDR: begin
                w_rd_addr = w_last;
                n_state   = ST_AX_CHK;
            end

            ST_AX_CHK: begin
                if (r_rd != CH_NONE && r_cursor >= w_last) begin
                    n_xkey  = KEY_RIGHT;
                    n_xauto = 1'b1;
                    n_exit  = 1'b1;
                    n_ptr   = '0;
                    n_seen  = 1'b0;
                    n_state = r_rj ? ST_TR_ADDR : ST_EMIT;
                end else begin
                    n_state = ST_ONE;
                end
            end

            ST_RIGHT: begin
                if (r_cursor < w_width && is_printable(r_rd)) n_cursor = r_cursor + POS_ONE;
                n_state = ST_ONE;
            end

            ST_TL: begin
                if (is_blank(i_cells[0])) begin
                    o_cmd = '{op: CELL_SHL, value: CH_NONE};
                end else begin
                    n_state = ST_TR_ADDR;
                end
            end

            ST_TR_ADDR: begin
                w_rd_addr = w_last;
                n_ptr     = w_last;
                n_state   = ST_TR_CHK;
            end

            ST_TR_CHK: begin
                if (r_rd == CH_SPACE) begin
                    o_cmd = '{op: CELL_FILL, value: CH_NONE};
                    o_lo  = r_ptr;
                    o_hi  = r_ptr;
                    if (r_ptr == '0) begin
                        n_state = r_exit ? ST_LEN_ADDR : ST_BEGIN_FIN;
                    end else begin
                        n_ptr     = r_ptr - POS_ONE;
                        w_rd_addr = r_ptr - POS_ONE;
                    end
                end else begin
                    n_state = r_exit ? ST_LEN_ADDR : ST_BEGIN_FIN;
                end
            end

            ST_BEGIN_FIN: begin
                n_empty = (i_cells[0] == CH_NONE);
                n_kind  = KIND_STATUS;
                n_state = ST_ONE;
            end

            ST_LEN_ADDR: begin
                n_ptr   = '0;
                n_state = ST_LEN;
            end

            ST_LEN: begin
                if (r_ptr == w_width || r_rd == CH_NONE) begin
                    if (r_exit) begin
                        n_cnt   = w_width - r_ptr;
                        n_state = ST_SHIFT;
                    end else begin
                        n_cursor = r_ptr;
                        n_kind   = KIND_STATUS;
                        n_state  = ST_ONE;
                    end
                end else begin
                    n_ptr     = r_ptr + POS_ONE;
                    w_rd_addr = r_ptr + POS_ONE;
                end
            end

            ST_SHIFT: begin
                // Moves the text to the right end, one cell per cycle, spaces entering at 0.
                if (r_cnt == '0) begin
                    n_ptr   = '0;
                    n_seen  = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd = '{op: CELL_SHR, value: CH_SPACE};
                    n_cnt = r_cnt - POS_ONE;
                end
            end

            ST_EMIT: begin
                // Pads after the first empty cell while the cells go out.
                if (w_out_free) begin
                    w_emit             = 1'b1;
                    w_res.kind         = KIND_CHAR;
                    w_res.cursor       = 7'(r_cursor);
                    w_res.insert_on    = r_ins;
                    w_res.was_modified = r_mod;
                    w_res.is_empty     = r_empty;
                    w_res.auto_exited  = r_xauto;
                    w_res.exit_key     = r_xkey;
                    w_res.out_index    = 6'(r_ptr);
                    w_res.out_char     = w_char;
                    w_res.last         = (r_ptr == w_last);
                    o_cmd              = '{op: CELL_FILL, value: w_char};
                    o_lo               = r_ptr;
                    o_hi               = r_ptr;
                    n_seen             = r_seen || (r_rd == CH_NONE);
                    if (r_ptr == w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_ptr     = r_ptr + POS_ONE;
                        w_rd_addr = r_ptr + POS_ONE;
                    end
                end else begin
                    w_rd_addr = r_ptr;
                end
            end

            ST_ONE: begin
                if (w_out_free) begin
                    w_emit             = 1'b1;
                    w_res.kind         = r_kind;
                    w_res.cursor       = 7'(r_cursor);
                    w_res.insert_on    = r_ins;
                    w_res.was_modified = r_mod;
                    w_res.is_empty     = r_empty;
                    w_res.last         = 1'b1;
                    n_state            = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cursor   <= '0;
            r_ins      <= 1'b0;
            r_mod      <= 1'b0;
            r_empty    <= 1'b0;
            r_fw       <= FIELD_WIDTH_RESET;
            r_autoexit <= 1'b0;
            r_rj       <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_ins    <= n_ins;
            r_mod    <= n_mod;
            r_empty  <= n_empty;
            r_ovalid <= w_emit || (r_ovalid && !i_out_ready);
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_FIELD_WIDTH:   r_fw       <= i_cfg.data;
                    CFG_AUTO_EXIT:     r_autoexit <= i_cfg.data[0];
                    CFG_RIGHT_JUSTIFY: r_rj       <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_ptr   <= n_ptr;
        r_cnt   <= n_cnt;
        r_seen  <= n_seen;
        r_exit  <= n_exit;
        r_xkey  <= n_xkey;
        r_xauto <= n_xauto;
        r_kind  <= n_kind;
        if (w_emit) r_out <= w_res;
        // Single read port into the cell row; data is seen in the next cycle.
        if (w_rd_addr < POS_MAX) begin
            r_rd <= i_cells[w_rd_addr[IW-1:0]];
        end else begin
            r_rd <= CH_NONE;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_res       = r_out;

endmodule

/* rtl/fixed_field_line_editor.sv */
// Top level of the fixed-field line editor: stream ports, the row of character cells
// and the sequencer. Depends on fll_pkg, fll_cell and fll_ctrl.
//
//   Port group    Dir  Carries
//   s_axis        in   one item: tuser = opcode, tdata = edit fields
//   m_axis        out  one result: tuser = kind, tdata = status and character, tlast
//   cfg           in   register writes: field width, exit on full, right justify
//
// One item at a time. A load writes one cell and gives no result; a key that only moves
// or edits gives one status or refusal result; begin trims the field and END scans it,
// one cell a cycle over the row of W cells. An exit emits W items, one a cycle while
// the output is not stalled, after trim, scan and shift steps when right justified.
// A stalled output freezes emission. Reset clears cursor, modes and flags;
// the cells keep their contents and hold nothing defined until loaded.
`timescale 1ns / 1ps

module fixed_field_line_editor
    import fll_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [5:0] char_index, [13:6] char_value, [20:14] start_cursor, [28:21] key_code
    input  logic [31:0]           i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [6:0] cursor, [7] insert_on, [8] was_modified, [9] is_empty, [10] auto_exited,
    // [18:11] exit_key, [24:19] out_index, [32:25] out_char
    output logic [39:0]           o_m_axis_tdata,
    // [1:0] kind
    output logic [1:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    t_byte     w_cells [MAX_WIDTH];
    t_cell_cmd w_cmd;
    logic [CW-1:0] w_lo;
    logic [CW-1:0] w_hi;
    t_item     w_item;
    t_result   w_res;
    t_cfg_wr   w_cfg;
    logic      w_out_valid;

    assign w_item.opcode       = i_s_axis_tuser;
    assign w_item.char_index   = i_s_axis_tdata[5:0];
    assign w_item.char_value   = i_s_axis_tdata[13:6];
    assign w_item.start_cursor = i_s_axis_tdata[20:14];
    assign w_item.key_code     = i_s_axis_tdata[28:21];

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_wdata;

    for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
        t_byte w_left;
        t_byte w_right;
        if (g == 0) begin : g_first
            assign w_left = CH_NONE;
        end else begin : g_inner_l
            assign w_left = w_cells[g-1];
        end
        if (g == MAX_WIDTH - 1) begin : g_top
            assign w_right = CH_NONE;
        end else begin : g_inner_r
            assign w_right = w_cells[g+1];
        end
        fll_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_lo    (w_lo),
            .i_hi    (w_hi),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_cells[g])
        );
    end

    fll_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_item      (w_item),
        .o_out_valid (w_out_valid),
        .i_out_ready (i_m_axis_tready),
        .o_res       (w_res),
        .i_cells     (w_cells),
        .o_cmd       (w_cmd),
        .o_lo        (w_lo),
        .o_hi        (w_hi)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tuser  = w_res.kind;
    assign o_m_axis_tlast  = w_res.last;
    assign o_m_axis_tdata  = {7'b0, w_res.out_char, w_res.out_index, w_res.exit_key,
                              w_res.auto_exited, w_res.is_empty, w_res.was_modified,
                              w_res.insert_on, w_res.cursor};

`ifndef ASSERT_OFF
    // Status and refused results are single items of their run.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_res.kind != KIND_CHAR) |-> w_res.last)
        else $error("single result without last");

    // Only exit characters carry index, character or exit information.
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_res.kind != KIND_CHAR) |->
        (w_res.out_char == CH_NONE && w_res.out_index == '0 &&
         w_res.exit_key == CH_NONE && !w_res.auto_exited))
        else $error("status result carries character data");

    // A refused key has already marked the field modified and non-empty.
    a_refuse_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_res.kind == KIND_REFUSE) |-> (w_res.was_modified && !w_res.is_empty))
        else $error("refused key with stale flags");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second item taken while one is at work");
`endif

endmodule

/* dv/fixed_field_line_editor_test.sv */
// Self-checking bench for the fixed-field line editor: random and directed items in,
// every result checked against an in-bench model. Depends on fll_pkg and the block RTL.
`timescale 1ns / 1ps

module fixed_field_line_editor_test;
    import fll_pkg::*;

    localparam int    CELLS           = 64;
    localparam int    CYCLE_LIMIT     = 4_000_000;
    localparam int    SETTLE_CYCLES   = 2 * CELLS + 12;
    localparam int    TAIL_CYCLES     = 3 * CELLS + 12;
    localparam int    END_WAIT_LIMIT  = 20_000;
    localparam int    ITEMS_PER_PHASE = 42;
    localparam int    PHASES          = 7;
    localparam t_byte CH_TILDE        = 8'h7E;
    localparam t_opcode OP_SPARE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Field state, expected results and their comparison.
    class line_editor_scoreboard;
        t_byte      cells [CELLS];
        int         cursor_pos;
        bit         insert_mode;
        bit         modified;
        bit         empty;
        logic [6:0] width_reg;
        bit         exit_on_full;
        bit         right_justify;
        t_result    pending_results [$];
        int         mismatches;
        int         results_checked;
        int         items_taken;
        int         exits;
        int         full_exits;
        int         refusals;

        function new();
            foreach (cells[i]) cells[i] = CH_NONE;
            width_reg = FIELD_WIDTH_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FIELD_WIDTH:   width_reg = data;
                CFG_AUTO_EXIT:     exit_on_full = data[0];
                CFG_RIGHT_JUSTIFY: right_justify = data[0];
                default: ;
            endcase
        endfunction

        function int cells_in_use();
            if (width_reg == 0) return 1;
            if (width_reg > CELLS) return CELLS;
            return int'(width_reg);
        endfunction

        function bit printable(t_byte c);
            return c >= CH_SPACE && c <= CH_TILDE;
        endfunction

        function int text_len(int w);
            int len;
            len = 0;
            while (len < w && cells[len] != CH_NONE) len++;
            return len;
        endfunction

        function void trim_trailing(int w);
            int i;
            i = w;
            while (i > 0 && cells[i-1] == CH_SPACE) begin
                cells[i-1] = CH_NONE;
                i--;
            end
        endfunction

        function void trim_leading(int w);
            int j;
            while (cells[0] == CH_SPACE || cells[0] == CH_TAB) begin
                for (j = 0; j < w - 1; j++) cells[j] = cells[j+1];
                cells[w-1] = CH_NONE;
            end
        endfunction

        // Text ends at the first empty cell; the rest is padding, placed first when right justified.
        function void pad_field(int w);
            int len;
            int j;
            if (right_justify) begin
                trim_trailing(w);
                len = text_len(w);
                for (j = len - 1; j >= 0; j--) cells[w - len + j] = cells[j];
                for (j = 0; j < w - len; j++) cells[j] = CH_SPACE;
            end else begin
                len = text_len(w);
                for (j = len; j < w; j++) cells[j] = CH_SPACE;
            end
        endfunction

        function void push_result(t_kind kind, bit autox, t_byte key, int idx, t_byte ch,
                                  bit last_one);
            t_result r;
            r.kind         = kind;
            r.cursor       = cursor_pos[6:0];
            r.insert_on    = insert_mode;
            r.was_modified = modified;
            r.is_empty     = empty;
            r.auto_exited  = autox;
            r.exit_key     = key;
            r.out_index    = idx[5:0];
            r.out_char     = ch;
            r.last         = last_one;
            pending_results.push_back(r);
        endfunction

        function void emit_field(int w, bit autox, t_byte key);
            int i;
            pad_field(w);
            for (i = 0; i < w; i++) push_result(KIND_CHAR, autox, key, i, cells[i], i == w - 1);
            exits++;
            if (autox) full_exits++;
        endfunction

        function void press_key(t_byte key, int w);
            int n;
            int i;
            n = w - 1;
            if (printable(key)) begin
                modified = 1'b1;
                empty    = 1'b0;
                if (insert_mode) begin
                    // A full last cell would be pushed out, so the key is refused.
                    if (printable(cells[n])) begin
                        refusals++;
                        push_result(KIND_REFUSE, 1'b0, CH_NONE, 0, CH_NONE, 1'b1);
                        return;
                    end
                    for (i = n; i > cursor_pos; i--) cells[i] = cells[i-1];
                end
                if (cursor_pos < w) begin
                    cells[cursor_pos] = key;
                    cursor_pos++;
                end
                // Auto exit reports the right-arrow code as the exit key.
                if (exit_on_full && cells[n] != CH_NONE && cursor_pos >= n) begin
                    emit_field(w, 1'b1, KEY_RIGHT);
                    return;
                end
            end else begin
                case (key)
                    KEY_BKSP: if (cursor_pos > 0) begin
                        if (insert_mode) begin
                            for (i = cursor_pos; i < w; i++) cells[i-1] = cells[i];
                            cells[n] = CH_NONE;
                        end
                        cursor_pos--;
                    end
                    KEY_LEFT: if (cursor_pos > 0) cursor_pos--;
                    KEY_RIGHT: if (cursor_pos < w && printable(cells[cursor_pos])) cursor_pos++;
                    KEY_INS: insert_mode = !insert_mode;
                    KEY_DEL: if (cursor_pos < w) begin
                        for (i = cursor_pos + 1; i < w; i++) cells[i-1] = cells[i];
                        cells[n] = CH_NONE;
                    end
                    KEY_HOME: cursor_pos = 0;
                    KEY_END: cursor_pos = text_len(w);
                    KEY_CLR_A, KEY_CLR_B: begin
                        cursor_pos = 0;
                        for (i = 0; i < w; i++) cells[i] = CH_NONE;
                        empty = 1'b1;
                    end
                    default: begin
                        emit_field(w, 1'b0, key);
                        return;
                    end
                endcase
            end
            push_result(KIND_STATUS, 1'b0, CH_NONE, 0, CH_NONE, 1'b1);
        endfunction

        function void note_item(t_item it);
            int w;
            w = cells_in_use();
            items_taken++;
            // A narrower width pulls a cursor that sits beyond it back to the end.
            if (cursor_pos > w) cursor_pos = w;
            case (it.opcode)
                OP_LOAD: cells[it.char_index] = it.char_value;
                OP_BEGIN: begin
                    modified = 1'b0;
                    if (right_justify) trim_leading(w);
                    trim_trailing(w);
                    empty = (cells[0] == CH_NONE);
                    cursor_pos = (it.start_cursor > w) ? w : int'(it.start_cursor);
                    push_result(KIND_STATUS, 1'b0, CH_NONE, 0, CH_NONE, 1'b1);
                end
                OP_KEY: press_key(it.key_code, w);
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (mismatches < 40) $display("ERROR at result %0d: %s", results_checked, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s is %h, model says %h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            results_checked++;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result, kind %h index %h", got.kind,
                                 got.out_index));
                return;
            end
            want = pending_results.pop_front();
            check_field("kind", got.kind, want.kind);
            check_field("cursor", got.cursor, want.cursor);
            check_field("insert_on", got.insert_on, want.insert_on);
            check_field("was_modified", got.was_modified, want.was_modified);
            check_field("is_empty", got.is_empty, want.is_empty);
            check_field("auto_exited", got.auto_exited, want.auto_exited);
            check_field("exit_key", got.exit_key, want.exit_key);
            check_field("out_index", got.out_index, want.out_index);
            check_field("out_char", got.out_char, want.out_char);
            check_field("last", got.last, want.last);
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [31:0]           s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [39:0]           m_tdata;
    wire  [1:0]            m_tuser;
    wire                   m_tlast;

    line_editor_scoreboard sb;
    int send_gap_pct   = 12;
    int recv_stall_pct = 63;
    int items_sent     = 0;
    int settings_used  = 1;
    int cycle_count    = 0;

    fixed_field_line_editor dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Both handshakes are observed here, the input before the output.
    always @(posedge clk) begin : observe
        t_item   taken;
        t_result got;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                taken.opcode       = s_tuser;
                taken.char_index   = s_tdata[5:0];
                taken.char_value   = s_tdata[13:6];
                taken.start_cursor = s_tdata[20:14];
                taken.key_code     = s_tdata[28:21];
                sb.note_item(taken);
            end
            if (m_tvalid && m_tready) begin
                got.kind         = m_tuser;
                got.cursor       = m_tdata[6:0];
                got.insert_on    = m_tdata[7];
                got.was_modified = m_tdata[8];
                got.is_empty     = m_tdata[9];
                got.auto_exited  = m_tdata[10];
                got.exit_key     = m_tdata[18:11];
                got.out_index    = m_tdata[24:19];
                got.out_char     = m_tdata[32:25];
                got.last         = m_tlast;
                if (m_tdata[39:33] !== '0) sb.report("filler bits of tdata are not zero");
                sb.check_result(got);
            end
        end
    end

    function automatic t_item random_item(input t_opcode op);
        t_item it;
        it.opcode       = op;
        it.char_index   = 6'($urandom_range(63));
        it.char_value   = t_byte'($urandom_range(255));
        it.start_cursor = 7'($urandom_range(127));
        it.key_code     = t_byte'($urandom_range(255));
        return it;
    endfunction

    function automatic t_byte random_char();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return t_byte'($urandom_range(CH_SPACE + 1, CH_TILDE));
            5, 6:          return CH_SPACE;
            7:             return CH_NONE;
            8:             return CH_TAB;
            default:       return t_byte'($urandom_range(255));
        endcase
    endfunction

    function automatic t_byte random_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return t_byte'($urandom_range(CH_SPACE, CH_TILDE));
        if (r < 88) begin
            case ($urandom_range(6))
                0:       return KEY_BKSP;
                1:       return KEY_LEFT;
                2:       return KEY_RIGHT;
                3:       return KEY_INS;
                4:       return KEY_DEL;
                5:       return KEY_HOME;
                default: return KEY_END;
            endcase
        end
        if (r < 92) return $urandom_range(1) ? KEY_CLR_A : KEY_CLR_B;
        return t_byte'($urandom_range(255));
    endfunction

    function automatic t_byte exit_key();
        t_byte k;
        do k = t_byte'($urandom_range(255));
        while ((k >= CH_SPACE && k <= CH_TILDE) || k inside {KEY_BKSP, KEY_LEFT, KEY_RIGHT,
               KEY_INS, KEY_DEL, KEY_HOME, KEY_END, KEY_CLR_A, KEY_CLR_B});
        return k;
    endfunction

    // Returns in the step of acceptance with tvalid still high; the caller either
    // presents the next item or lowers tvalid in that same step.
    task automatic send_item(input t_item it);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.opcode;
        s_tdata  <= {3'b000, it.key_code, it.start_cursor, it.char_value, it.char_index};
        do @(posedge clk); while (!s_tready);
        if (it.opcode != OP_SPARE) items_sent++;
    endtask

    task automatic load_cell(input int idx, input t_byte val);
        t_item it;
        it = random_item(OP_LOAD);
        it.char_index = idx[5:0];
        it.char_value = val;
        send_item(it);
    endtask

    task automatic begin_edit(input int start);
        t_item it;
        it = random_item(OP_BEGIN);
        it.start_cursor = start[6:0];
        send_item(it);
    endtask

    task automatic press(input t_byte key);
        t_item it;
        it = random_item(OP_KEY);
        it.key_code = key;
        send_item(it);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [6:0] width, input bit autox, input bit rjust,
                              input bit poke_unused);
        wait_until_drained();
        // A load leaves no result behind, so give the block time to finish it.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(CFG_FIELD_WIDTH, width);
        cfg_write(CFG_AUTO_EXIT, {6'b0, autox});
        cfg_write(CFG_RIGHT_JUSTIFY, {6'b0, rjust});
        if (poke_unused) cfg_write(CFG_UNUSED, 7'($urandom_range(127)));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly load, begin, keys and an exit; sometimes keys arrive with no begin.
    task automatic edit_session(input int w);
        int n_loads;
        int n_keys;
        int k;
        n_loads = $urandom_range(0, 4);
        for (k = 0; k < n_loads; k++)
            load_cell($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(w - 1),
                      random_char());
        if ($urandom_range(19) == 0) send_item(random_item(OP_SPARE));
        if ($urandom_range(9) != 0)
            begin_edit($urandom_range(7) == 0 ? $urandom_range(127) : $urandom_range(w));
        n_keys = $urandom_range(3, 14);
        for (k = 0; k < n_keys; k++) press(random_key());
        if ($urandom_range(3) != 0) press(exit_key());
        if ($urandom_range(11) == 0) wait_until_drained();
    endtask

    initial begin
        logic [6:0] phase_width [PHASES];
        bit         phase_auto  [PHASES];
        bit         phase_rjust [PHASES];
        int         p;
        int         i;
        int         start_count;
        int         waited;

        phase_width = '{7'd8, 7'd0, 7'd127, 7'd1, 7'd2, 7'd64, 7'd1};
        phase_auto  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_rjust = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        phase_width[4] = 7'($urandom_range(2, 20));
        phase_width[6] = 7'($urandom_range(1, 64));
        phase_auto[6]  = 1'($urandom_range(1));
        phase_rjust[6] = 1'($urandom_range(1));

        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs at the reset width, right justified.
        cfg_write(CFG_RIGHT_JUSTIFY, 7'd1);
        cfg_we <= 1'b0;
        for (i = 0; i < CELLS; i++) load_cell(i, random_char());

        press(8'h41);
        send_item(t_item'('1));
        load_cell(0, CH_SPACE);
        load_cell(1, CH_TAB);
        load_cell(CELLS - 1, 8'hFF);
        begin_edit(127);
        press(CH_TILDE);
        press(KEY_HOME);
        press(KEY_INS);
        load_cell(CELLS - 1, 8'h51);
        press(CH_SPACE);
        load_cell(CELLS - 1, CH_NONE);
        press(8'h62);
        press(KEY_BKSP);
        press(KEY_INS);
        press(KEY_BKSP);
        press(KEY_END);
        press(KEY_LEFT);
        press(KEY_RIGHT);
        press(KEY_DEL);
        press(KEY_CLR_A);
        begin_edit(0);
        press(8'h7A);
        press(KEY_CLR_B);
        press(8'h00);
        press(8'h7F);

        for (p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                send_gap_pct   = 12;
                recv_stall_pct = 63;
            end else if (p < 4) begin
                send_gap_pct   = 63;
                recv_stall_pct = 12;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            set_config(phase_width[p], phase_auto[p], phase_rjust[p], p == 3);
            start_count = items_sent;
            while (items_sent - start_count < ITEMS_PER_PHASE)
                edit_session(sb.cells_in_use());
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.pending_results.size()));

        $display("Run took %0d items and checked %0d results under %0d register settings.",
                 sb.items_taken, sb.results_checked, settings_used);
        $display("It saw %0d field exits (%0d automatic) and %0d refused keys.",
                 sb.exits, sb.full_exits, sb.refusals);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
